[hdl/line_rasterizer_defines.svh]
// assertion macros used by the line rasterizer top level
`ifndef LINE_RASTERIZER_DEFINES_SVH
`define LINE_RASTERIZER_DEFINES_SVH

// condition on the same edge
`define LR_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("line rasterizer check failed");

// condition on the following edge
`define LR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("line rasterizer check failed");

`endif

[hdl/lr_pkg.sv]
// types and constants of the line rasterizer
`timescale 1ns / 1ps

package lr_pkg;

  localparam int unsigned COORD_W = 16;
  localparam int unsigned COLOR_W = 16;
  localparam int unsigned ERR_W   = COORD_W + 1;
  localparam int unsigned CNT_W   = COORD_W + 1;

  // operation codes on the line channel
  localparam logic OP_START   = 1'b0;
  localparam logic OP_ADVANCE = 1'b1;

  typedef enum logic [1:0] {
    DIR_NONE = 2'd0,
    DIR_UP   = 2'd1,
    DIR_DOWN = 2'd3
  } dir_e;

  // fixed geometry of the active line
  typedef struct packed {
    dir_e               dir_col;
    dir_e               dir_row;
    logic [COORD_W-1:0] abs_dcol;
    logic [COORD_W-1:0] abs_drow;
    logic [COORD_W-1:0] span;
  } geom_t;

  // running position and error terms
  typedef struct packed {
    logic [COORD_W-1:0] cur_col;
    logic [COORD_W-1:0] cur_row;
    logic [ERR_W-1:0]   err_col;
    logic [ERR_W-1:0]   err_row;
  } track_t;

  typedef struct packed {
    logic [COORD_W-1:0] point_x;
    logic [COORD_W-1:0] point_y;
    logic [COLOR_W-1:0] point_color;
    logic               last;
  } point_t;

endpackage

[hdl/lr_if.sv]
// channel interfaces of the line rasterizer
`timescale 1ns / 1ps

interface lr_line_if;
  logic                       valid;
  logic                       ready;
  logic                       op;
  logic [lr_pkg::COORD_W-1:0] x_start;
  logic [lr_pkg::COORD_W-1:0] y_start;
  logic [lr_pkg::COORD_W-1:0] x_end;
  logic [lr_pkg::COORD_W-1:0] y_end;
  logic [lr_pkg::COLOR_W-1:0] color;

  modport source (output valid, op, x_start, y_start, x_end, y_end, color, input ready);
  modport sink (input valid, op, x_start, y_start, x_end, y_end, color, output ready);
endinterface

interface lr_point_if;
  logic                       valid;
  logic                       ready;
  logic [lr_pkg::COORD_W-1:0] point_x;
  logic [lr_pkg::COORD_W-1:0] point_y;
  logic [lr_pkg::COLOR_W-1:0] point_color;
  logic                       last;

  modport source (output valid, point_x, point_y, point_color, last, input ready);
  modport sink (input valid, point_x, point_y, point_color, last, output ready);
endinterface

[hdl/lr_setup.sv]
// line setup: direction, absolute delta and span from two endpoints
`timescale 1ns / 1ps

module lr_setup (
  input  logic [lr_pkg::COORD_W-1:0] x_start_i,
  input  logic [lr_pkg::COORD_W-1:0] y_start_i,
  input  logic [lr_pkg::COORD_W-1:0] x_end_i,
  input  logic [lr_pkg::COORD_W-1:0] y_end_i,
  output lr_pkg::geom_t              geom_o
);

  always_comb begin
    geom_o = '0;
    if (x_end_i > x_start_i) begin
      geom_o.dir_col  = lr_pkg::DIR_UP;
      geom_o.abs_dcol = x_end_i - x_start_i;
    end else if (x_end_i < x_start_i) begin
      geom_o.dir_col  = lr_pkg::DIR_DOWN;
      geom_o.abs_dcol = x_start_i - x_end_i;
    end else begin
      geom_o.dir_col  = lr_pkg::DIR_NONE;
      geom_o.abs_dcol = '0;
    end
    if (y_end_i > y_start_i) begin
      geom_o.dir_row  = lr_pkg::DIR_UP;
      geom_o.abs_drow = y_end_i - y_start_i;
    end else if (y_end_i < y_start_i) begin
      geom_o.dir_row  = lr_pkg::DIR_DOWN;
      geom_o.abs_drow = y_start_i - y_end_i;
    end else begin
      geom_o.dir_row  = lr_pkg::DIR_NONE;
      geom_o.abs_drow = '0;
    end
    geom_o.span = (geom_o.abs_dcol > geom_o.abs_drow) ? geom_o.abs_dcol : geom_o.abs_drow;
  end

endmodule

[hdl/lr_advance.sv]
// one stepping update: error accumulation and conditional axis step
`timescale 1ns / 1ps

module lr_advance (
  input  lr_pkg::geom_t  geom_i,
  input  lr_pkg::track_t track_i,
  output lr_pkg::track_t track_o
);

  logic [lr_pkg::ERR_W-1:0] sum_col;
  logic [lr_pkg::ERR_W-1:0] sum_row;
  logic [lr_pkg::ERR_W-1:0] span_ext;

  always_comb begin
    span_ext = {1'b0, geom_i.span};
    sum_col  = track_i.err_col + {1'b0, geom_i.abs_dcol};
    sum_row  = track_i.err_row + {1'b0, geom_i.abs_drow};
    track_o  = track_i;
    track_o.err_col = sum_col;
    track_o.err_row = sum_row;

    if (sum_col > span_ext) begin
      track_o.err_col = sum_col - span_ext;
      unique case (geom_i.dir_col)
        lr_pkg::DIR_UP:   track_o.cur_col = track_i.cur_col + 1'b1;
        lr_pkg::DIR_DOWN: track_o.cur_col = track_i.cur_col - 1'b1;
        default:          track_o.cur_col = track_i.cur_col;
      endcase
    end

    if (sum_row > span_ext) begin
      track_o.err_row = sum_row - span_ext;
      unique case (geom_i.dir_row)
        lr_pkg::DIR_UP:   track_o.cur_row = track_i.cur_row + 1'b1;
        lr_pkg::DIR_DOWN: track_o.cur_row = track_i.cur_row - 1'b1;
        default:          track_o.cur_row = track_i.cur_row;
      endcase
    end
  end

endmodule

[hdl/lr_point_reg.sv]
// result register driving the point channel
`timescale 1ns / 1ps

module lr_point_reg (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  lr_pkg::point_t    point_i,
  output logic              free_o,
  lr_point_if.source        point_o
);

  logic           valid_q;
  logic           valid_d;
  lr_pkg::point_t data_q;

  // slot is free when empty or being drained this cycle
  assign free_o  = !valid_q || point_o.ready;
  assign valid_d = load_i || (valid_q && !point_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= point_i;
    end
  end

  assign point_o.valid       = valid_q;
  assign point_o.point_x     = data_q.point_x;
  assign point_o.point_y     = data_q.point_y;
  assign point_o.point_color = data_q.point_color;
  assign point_o.last        = data_q.last;

endmodule

[hdl/line_rasterizer.sv]
// line rasterizer top level: line state registers and point output
`timescale 1ns / 1ps
`include "line_rasterizer_defines.svh"

// Integer line rasterizer. A start transaction (op = 0) on line_i loads two
// endpoints and a colour and produces no point. Each advance transaction
// (op = 1) then produces one point on point_o, span + 1 points in all, where
// span is the larger of the two absolute deltas; the final point carries
// last = 1. An advance with no active line is taken and dropped, and a start
// while a line is active replaces it. Coordinates wrap modulo 65536. One
// transaction is taken every cycle unless stalled; a point appears on
// point_o the cycle after its advance is taken. line_i.ready falls only while
// the single point register holds an untaken point and point_o.ready is low.

module line_rasterizer (
  input  logic        clk_i,
  input  logic        rst_ni,
  lr_line_if.sink     line_i,
  lr_point_if.source  point_o
);

  // handshake decode
  logic line_acc;
  logic is_start;
  logic emit;
  logic out_free;

  // line state
  lr_pkg::geom_t              geom_q;
  lr_pkg::geom_t              geom_d;
  lr_pkg::track_t             track_q;
  lr_pkg::track_t             track_d;
  logic [lr_pkg::CNT_W-1:0]   points_left_q;
  logic [lr_pkg::CNT_W-1:0]   points_left_d;
  logic [lr_pkg::COLOR_W-1:0] line_color_q;
  logic [lr_pkg::COLOR_W-1:0] line_color_d;
  logic                       busy_q;
  logic                       busy_d;

  // combinational results
  lr_pkg::geom_t  geom_new;
  lr_pkg::track_t track_step;
  lr_pkg::point_t point_new;

  assign line_i.ready = out_free;
  assign line_acc     = line_i.valid && line_i.ready;
  assign is_start     = (line_i.op == lr_pkg::OP_START);
  assign emit         = line_acc && !is_start && busy_q;

  lr_setup u_setup (
    .x_start_i (line_i.x_start),
    .y_start_i (line_i.y_start),
    .x_end_i   (line_i.x_end),
    .y_end_i   (line_i.y_end),
    .geom_o    (geom_new)
  );

  lr_advance u_advance (
    .geom_i  (geom_q),
    .track_i (track_q),
    .track_o (track_step)
  );

  // point leaves with the pre-step position
  always_comb begin
    point_new.point_x     = track_q.cur_col;
    point_new.point_y     = track_q.cur_row;
    point_new.point_color = line_color_q;
    point_new.last        = (points_left_q == lr_pkg::CNT_W'(1));
  end

  // next line state
  always_comb begin
    geom_d        = geom_q;
    track_d       = track_q;
    points_left_d = points_left_q;
    line_color_d  = line_color_q;
    busy_d        = busy_q;
    if (line_acc && is_start) begin
      geom_d          = geom_new;
      track_d.cur_col = line_i.x_start;
      track_d.cur_row = line_i.y_start;
      track_d.err_col = '0;
      track_d.err_row = '0;
      points_left_d   = {1'b0, geom_new.span} + lr_pkg::CNT_W'(1);
      line_color_d    = line_i.color;
      busy_d          = 1'b1;
    end else if (emit) begin
      track_d       = track_step;
      points_left_d = points_left_q - lr_pkg::CNT_W'(1);
      busy_d        = (points_left_q != lr_pkg::CNT_W'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      geom_q        <= '0;
      track_q       <= '0;
      points_left_q <= '0;
      line_color_q  <= '0;
      busy_q        <= 1'b0;
    end else begin
      geom_q        <= geom_d;
      track_q       <= track_d;
      points_left_q <= points_left_d;
      line_color_q  <= line_color_d;
      busy_q        <= busy_d;
    end
  end

  lr_point_reg u_point_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (emit),
    .point_i (point_new),
    .free_o  (out_free),
    .point_o (point_o)
  );

  // active line always has points outstanding
  `LR_ASSERT_SAME(a_busy_count, clk_i, rst_ni, 1'b1, busy_q == (points_left_q != '0))
  // error terms never pass the span
  `LR_ASSERT_SAME(a_err_bound, clk_i, rst_ni, busy_q,
    (track_q.err_col <= {1'b0, geom_q.span}) && (track_q.err_row <= {1'b0, geom_q.span}))
  // an accepted advance on an active line yields a point
  `LR_ASSERT_NEXT(a_emit_point, clk_i, rst_ni, emit, point_o.valid)
  // the final point closes the line
  `LR_ASSERT_NEXT(a_last_idle, clk_i, rst_ni, emit && point_new.last, !busy_q)

endmodule
